// File: hdl/esk_pkg.sv
// Shared types, constants and helper functions for the EAPOL success key extractor.
// Used by every module of the block and by the stream interface instances.
// Depends on nothing.
package esk_pkg;

    // Position counter and frame layout.
    localparam int unsigned PosWidth = 9;
    localparam int unsigned HdrLen   = 20;
    localparam int unsigned KeyBytes = 4;
    localparam int unsigned SeenWidth = 3;

    localparam logic [PosWidth-1:0] POS_MAX    = 9'd511;
    localparam logic [PosWidth-1:0] KEY_BASE   = 9'd157;
    localparam logic [PosWidth-1:0] OFS_SKIP   = 9'h1B;
    localparam logic [PosWidth-1:0] OFS_MARKER = 9'h2C;

    // Header byte offsets that the classifier looks at.
    localparam int unsigned OFS_TYPE_HI = 'h0C;
    localparam int unsigned OFS_TYPE_LO = 'h0D;
    localparam int unsigned OFS_CODE    = 'h0F;
    localparam int unsigned OFS_HB0     = 'h10;
    localparam int unsigned OFS_HB1     = 'h11;
    localparam int unsigned OFS_HB2     = 'h12;
    localparam int unsigned OFS_HB3     = 'h13;

    // Values that are matched.
    localparam logic [7:0] ETH_TYPE_HI  = 8'h88;
    localparam logic [7:0] ETH_TYPE_LO  = 8'h8E;
    localparam logic [7:0] CODE_SUCCESS = 8'h03;
    localparam logic [7:0] HB_LEN       = 8'h1E;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;

    localparam logic [31:0] KEY_ADD = 32'h0000_102B;

    // Frame kind codes.
    localparam logic [1:0] KIND_OTHER     = 2'd0;
    localparam logic [1:0] KIND_SUCCESS   = 2'd1;
    localparam logic [1:0] KIND_HEARTBEAT = 2'd2;

    // One input item: a frame byte and its end flag.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } frame_item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [47:0] local_mac;
        logic [47:0] peer_mac;
        logic [31:0] echo_key;
        logic        key_valid;
        logic [15:0] heartbeat_count;
    } result_item_t;

    // Frame contents as they stand with the current byte included.
    typedef struct packed {
        logic [HdrLen-1:0][7:0] header;
        logic [7:0]             marker;
        logic [31:0]            key_word;
        logic                   key_complete;
    } frame_view_t;

    // Bit-reverse a byte, then invert it.
    function automatic logic [7:0] flip_invert(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = b[7-k];
        end
        return ~r;
    endfunction

endpackage

// File: hdl/esk_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
// The payload type is set per instance, normally from esk_pkg.
interface esk_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/esk_frame_tracker.sv
// Per-frame byte tracking: position counter, stored header, skip byte, marker and key bytes.
// Presents the frame contents including the byte being processed. Depends on esk_pkg.
module esk_frame_tracker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  esk_pkg::frame_item_t item,
    output esk_pkg::frame_view_t view
);

    logic [esk_pkg::PosWidth-1:0]               pos_reg, pos_next;
    logic [esk_pkg::HdrLen-1:0][7:0]            header_reg, header_next, header_cur;
    logic [7:0]                                 skip_reg, skip_next;
    logic [7:0]                                 marker_reg, marker_next, marker_cur;
    logic [esk_pkg::KeyBytes-1:0][7:0]          key_reg, key_next, key_cur;
    logic [esk_pkg::SeenWidth-1:0]              seen_reg, seen_next, seen_cur;
    logic [esk_pkg::PosWidth-1:0]               key_pos;
    logic [esk_pkg::PosWidth-1:0]               key_diff;
    logic                                       in_key;

    // Merge the current byte into the stored frame contents.
    always_comb
    begin
        key_pos  = esk_pkg::KEY_BASE + {1'b0, skip_reg};
        key_diff = pos_reg - key_pos;
        in_key   = (pos_reg >= key_pos) && (key_diff < esk_pkg::PosWidth'(esk_pkg::KeyBytes));
        for (int i = 0; i < esk_pkg::HdrLen; i++)
        begin
            header_cur[i] = (pos_reg == esk_pkg::PosWidth'(i)) ? item.frame_byte
                                                                : header_reg[i];
        end
        marker_cur = (pos_reg == esk_pkg::OFS_MARKER) ? item.frame_byte : marker_reg;
        for (int j = 0; j < esk_pkg::KeyBytes; j++)
        begin
            key_cur[j] = (in_key && (key_diff[1:0] == 2'(j))) ? item.frame_byte : key_reg[j];
        end
        seen_cur = seen_reg + esk_pkg::SeenWidth'(in_key);
    end

    assign view.header       = header_cur;
    assign view.marker       = marker_cur;
    assign view.key_word     = {key_cur[0], key_cur[1], key_cur[2], key_cur[3]};
    assign view.key_complete = (seen_cur >= esk_pkg::SeenWidth'(esk_pkg::KeyBytes));

    // Advance the frame state; the last byte clears everything for the next frame.
    always_comb
    begin
        pos_next    = pos_reg;
        header_next = header_reg;
        skip_next   = skip_reg;
        marker_next = marker_reg;
        key_next    = key_reg;
        seen_next   = seen_reg;
        if (step)
        begin
            if (item.frame_end)
            begin
                pos_next    = '0;
                header_next = '0;
                skip_next   = '0;
                marker_next = '0;
                key_next    = '0;
                seen_next   = '0;
            end
            else
            begin
                pos_next    = (pos_reg == esk_pkg::POS_MAX) ? pos_reg : pos_reg + 1'b1;
                header_next = header_cur;
                skip_next   = (pos_reg == esk_pkg::OFS_SKIP) ? item.frame_byte : skip_reg;
                marker_next = marker_cur;
                key_next    = key_cur;
                seen_next   = seen_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            header_reg <= '0;
            skip_reg   <= '0;
            marker_reg <= '0;
            key_reg    <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            header_reg <= header_next;
            skip_reg   <= skip_next;
            marker_reg <= marker_next;
            key_reg    <= key_next;
            seen_reg   <= seen_next;
        end
    end

    // Key byte positions are distinct, so no more than four are ever counted.
    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= esk_pkg::SeenWidth'(esk_pkg::KeyBytes))
        else $error("key byte count exceeded four");

    // A saturated position stays put until the frame ends.
    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.frame_end && pos_reg == esk_pkg::POS_MAX |=> pos_reg == esk_pkg::POS_MAX)
        else $error("byte position wrapped");

    // The last byte of a frame returns the tracker to its start.
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.frame_end |=> pos_reg == '0 && seen_reg == '0)
        else $error("frame state not cleared after last byte");

endmodule

// File: hdl/esk_classifier.sv
// Frame classification, MAC latching, key derivation and heartbeat counting.
// Holds the persistent state that forms the result item. Depends on esk_pkg.
module esk_classifier (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  esk_pkg::frame_view_t view,
    output esk_pkg::result_item_t result_item
);

    logic [1:0]  kind_reg, kind_next;
    logic [47:0] local_mac_reg, local_mac_next;
    logic [47:0] peer_mac_reg, peer_mac_next;
    logic [31:0] echo_key_reg, echo_key_next;
    logic        key_valid_reg, key_valid_next;
    logic [15:0] hb_count_reg, hb_count_next;
    logic        is_eapol;
    logic        is_success;
    logic        is_heartbeat;
    logic [31:0] key_flipped;

    // Recognise the frame from the header bytes and the marker.
    always_comb
    begin
        is_eapol = (view.header[esk_pkg::OFS_TYPE_HI] == esk_pkg::ETH_TYPE_HI)
                && (view.header[esk_pkg::OFS_TYPE_LO] == esk_pkg::ETH_TYPE_LO);
        is_success = is_eapol
                && (view.header[esk_pkg::OFS_CODE] == esk_pkg::BYTE_ZERO)
                && (view.header[esk_pkg::OFS_HB2] == esk_pkg::CODE_SUCCESS);
        is_heartbeat = is_eapol && !is_success
                && (view.header[esk_pkg::OFS_HB0] == esk_pkg::BYTE_ZERO)
                && (view.header[esk_pkg::OFS_HB1] == esk_pkg::HB_LEN)
                && (view.header[esk_pkg::OFS_HB2] == esk_pkg::BYTE_ONES)
                && (view.header[esk_pkg::OFS_HB3] == esk_pkg::BYTE_ONES)
                && (view.marker == esk_pkg::BYTE_ONES);
        key_flipped = {esk_pkg::flip_invert(view.key_word[31:24]),
                       esk_pkg::flip_invert(view.key_word[23:16]),
                       esk_pkg::flip_invert(view.key_word[15:8]),
                       esk_pkg::flip_invert(view.key_word[7:0])};
    end

    // Update the persistent state at the last byte of a frame.
    always_comb
    begin
        kind_next      = kind_reg;
        local_mac_next = local_mac_reg;
        peer_mac_next  = peer_mac_reg;
        echo_key_next  = echo_key_reg;
        key_valid_next = key_valid_reg;
        hb_count_next  = hb_count_reg;
        if (load)
        begin
            priority if (is_success)
            begin
                kind_next      = esk_pkg::KIND_SUCCESS;
                hb_count_next  = '0;
                local_mac_next = {view.header[0], view.header[1], view.header[2],
                                  view.header[3], view.header[4], view.header[5]};
                peer_mac_next  = {view.header[6], view.header[7], view.header[8],
                                  view.header[9], view.header[10], view.header[11]};
                echo_key_next  = view.key_complete ? key_flipped + esk_pkg::KEY_ADD : '0;
                key_valid_next = view.key_complete;
            end
            else if (is_heartbeat)
            begin
                kind_next     = esk_pkg::KIND_HEARTBEAT;
                hb_count_next = hb_count_reg + 1'b1;
            end
            else
            begin
                kind_next = esk_pkg::KIND_OTHER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= esk_pkg::KIND_OTHER;
            local_mac_reg <= '0;
            peer_mac_reg  <= '0;
            echo_key_reg  <= '0;
            key_valid_reg <= 1'b0;
            hb_count_reg  <= '0;
        end
        else
        begin
            kind_reg      <= kind_next;
            local_mac_reg <= local_mac_next;
            peer_mac_reg  <= peer_mac_next;
            echo_key_reg  <= echo_key_next;
            key_valid_reg <= key_valid_next;
            hb_count_reg  <= hb_count_next;
        end
    end

    assign result_item.frame_kind      = kind_reg;
    assign result_item.local_mac       = local_mac_reg;
    assign result_item.peer_mac        = peer_mac_reg;
    assign result_item.echo_key        = echo_key_reg;
    assign result_item.key_valid       = key_valid_reg;
    assign result_item.heartbeat_count = hb_count_reg;

    // A success frame restarts the heartbeat count.
    a_success_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        load && is_success |=> hb_count_reg == '0 && kind_reg == esk_pkg::KIND_SUCCESS)
        else $error("heartbeat count not cleared by success frame");

    // A heartbeat frame advances the count by exactly one.
    a_heartbeat_counts: assert property (@(posedge clk) disable iff (!rst_n)
        load && is_heartbeat |=> hb_count_reg == $past(hb_count_reg) + 16'd1)
        else $error("heartbeat count did not advance");

    // Without a complete key the key word reads as zero.
    a_key_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        !key_valid_reg |-> echo_key_reg == '0)
        else $error("echo key set while key marked invalid");

endmodule

// File: hdl/eapol_success_key_extractor.sv
// EAPOL success / heartbeat watcher with echo-key derivation, top level.
// Takes one frame byte per cycle; throughput is one item per clock when results are taken.
// A frame's last byte is held in the input register; its result is then registered and
// shown as valid from the result register. Other bytes give no result.
// Reset (rst_n, asynchronous, active low) clears all frame state, MACs, key and count.
// Depends on esk_pkg, esk_stream_if, esk_frame_tracker and esk_classifier.
module eapol_success_key_extractor (
    input  logic         clk,
    input  logic         rst_n,
    esk_stream_if.sink   frame,
    esk_stream_if.source result
);

    logic                  in_valid_reg, in_valid_next;
    esk_pkg::frame_item_t  in_item_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  advance;
    logic                  take;
    logic                  step;
    esk_pkg::frame_view_t  view;
    esk_pkg::result_item_t result_item;

    // Handshake: the held item moves on whenever the result register is free or draining.
    assign advance     = !out_valid_reg || result.ready;
    assign frame.ready = advance || !in_valid_reg;
    assign take        = frame.valid && frame.ready;
    assign step        = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? (in_valid_reg && in_item_reg.frame_end) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= frame.payload;
        end
    end

    esk_frame_tracker u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .view  (view)
    );

    esk_classifier u_classifier (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step && in_item_reg.frame_end),
        .view        (view),
        .result_item (result_item)
    );

    assign result.valid   = out_valid_reg;
    assign result.payload = result_item;

    // A byte that does not end a frame leaves no result behind.
    a_no_result_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        step && !in_item_reg.frame_end |=> !out_valid_reg)
        else $error("result raised for a byte inside a frame");

    // The last byte of a frame always produces a result.
    a_result_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_item_reg.frame_end |=> out_valid_reg)
        else $error("no result for the last byte of a frame");

    // A held item is never dropped while the result side stalls.
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled input item lost");

endmodule
